// ===== rtl/core/lle_pkg.sv =====
package lle_pkg;

  // Pool geometry and field widths.
  localparam int NODES  = 256;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = $clog2(NODES);
  localparam int SLOT_W = $clog2(NODES + 1);
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;

  // Slot code that stands for the end of a chain.
  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(NODES);
  // Step index at which a value walk stops moving on.
  localparam logic [SLOT_W-1:0] STEP_LAST = SLOT_W'(NODES - 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INS_HEAD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_HEAD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_TAIL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_VALUE = 3'd5;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  // Command word taken on start.
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] item_value;
    logic signed [VAL_W-1:0] match_value;
  } cmd_word_t;

  // Result word shown with done.
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] entry_total;
  } result_word_t;

  // Access request to the node store.
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_data_en;
    logic              wr_link_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [SLOT_W-1:0] wr_link;
  } store_req_t;

  // Read data from the node store, registered and valid in the cycle after the request.
  typedef struct packed {
    logic [VAL_W-1:0]  data;
    logic [SLOT_W-1:0] link;
  } store_rsp_t;

endpackage

// ===== rtl/core/lle_store.sv =====
module lle_store import lle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  store_req_t req,
  output store_rsp_t rsp
);

  logic [VAL_W-1:0]  data_mem [NODES];
  logic [SLOT_W-1:0] link_mem [NODES];

  // Slots at or above the fill mark were never written and still hold
  // their reset chain, where each slot points at the one after it.
  logic [SLOT_W-1:0] fill_mark;

  logic [VAL_W-1:0]  data_raw;
  logic [SLOT_W-1:0] link_raw;
  logic              data_byp;
  logic              link_byp;
  logic              link_fresh;
  logic [VAL_W-1:0]  data_alt;
  logic [SLOT_W-1:0] link_alt;

  // Value memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (req.wr_data_en) begin
      data_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_raw <= data_mem[req.rd_addr];
    end
  end

  // Link memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (req.wr_link_en) begin
      link_mem[req.wr_addr] <= req.wr_link;
    end
    if (req.rd_en) begin
      link_raw <= link_mem[req.rd_addr];
    end
  end

  // Read-side selection, registered alongside the memory read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      data_byp   <= req.wr_data_en && (req.wr_addr == req.rd_addr);
      link_byp   <= req.wr_link_en && (req.wr_addr == req.rd_addr);
      link_fresh <= {1'b0, req.rd_addr} >= fill_mark;
      data_alt   <= req.wr_data;
      link_alt   <= (req.wr_link_en && (req.wr_addr == req.rd_addr)) ?
                    req.wr_link : ({1'b0, req.rd_addr} + SLOT_W'(1));
    end
  end

  // The fill mark moves past every slot whose link gets written.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mark <= '0;
    end else if (req.wr_link_en && ({1'b0, req.wr_addr} >= fill_mark)) begin
      fill_mark <= {1'b0, req.wr_addr} + SLOT_W'(1);
    end
  end

  assign rsp.data = data_byp ? data_alt : data_raw;
  assign rsp.link = (link_byp || link_fresh) ? link_alt : link_raw;

endmodule

// ===== rtl/core/linked_list_engine_core.sv =====
// Linked list engine: a singly linked list of up to 256 signed 32-bit values
// held in a node pool with a free list.
// Command channel: a command word is taken at a rising edge where start is
// high and busy is low. busy stays high while the command is worked on.
// Result channel: done is high for exactly one cycle, with status and the
// node count after the command on result. Results cannot be held off.
// States passed from the accepting edge to done:
//   unused codes, full pool on insert head or tail, empty list: decode
//   insert head, delete head, insert tail into an empty list: decode, write
//   no match found, or a match found with the pool full: decode, walk
//   delete tail, delete value: decode, walk, free; insert after: decode,
//   walk, ins A, ins B; insert tail: decode, pop tail, walk, tail new
// The walk visits at most 256 nodes, at most 255 for an insert that succeeds,
// one node per cycle through the link memory read port, which sets the rate.
// busy drops in the cycle where done is high, so the next command may be
// taken there; one command is in work at a time.
// Reset empties the list and chains every slot into the free list; the block
// takes commands in the cycle after reset is released, with no sweep.
module linked_list_engine_core import lle_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  cmd_word_t    command,
  output logic         busy,
  output logic         done,
  output result_word_t result
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH_HEAD,
    S_POP_TAIL,
    S_WALK,
    S_TAIL_NEW,
    S_INS_A,
    S_INS_B,
    S_DEL_HEAD,
    S_FREE_T
  } state_t;

  state_t            state;
  logic [CMD_W-1:0]  op;
  logic [VAL_W-1:0]  item;
  logic [VAL_W-1:0]  match;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] count;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] prev;
  logic [SLOT_W-1:0] steps;
  logic [SLOT_W-1:0] tnext;
  logic [SLOT_W-1:0] nfree;
  logic [ST_W-1:0]   status_q;

  store_req_t mem_req;
  store_rsp_t mem_rsp;

  logic head_node;
  logic free_node;
  logic prev_node;
  logic link_node;
  logic tail_walk;
  logic hit;
  logic walk_adv;

  lle_store u_store (
    .clk (clk),
    .rst (rst),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  // Walk decisions on the node read back this cycle.
  always_comb begin
    head_node = head < NULL_SLOT;
    free_node = free_slot < NULL_SLOT;
    prev_node = prev < NULL_SLOT;
    link_node = mem_rsp.link < NULL_SLOT;
    tail_walk = (op == CMD_INS_TAIL) || (op == CMD_DEL_TAIL);
    hit       = mem_rsp.data == match;
    if (tail_walk) begin
      walk_adv = link_node && (steps < NULL_SLOT);
    end else begin
      walk_adv = !hit && link_node && (steps < STEP_LAST);
    end
  end

  // Store accesses for each step of a command.
  always_comb begin
    mem_req = '0;
    unique case (state)
      S_DECODE: begin
        if ((op == CMD_INS_HEAD) || (op == CMD_INS_TAIL)) begin
          mem_req.rd_en   = free_node;
          mem_req.rd_addr = free_slot[IDX_W-1:0];
        end else begin
          mem_req.rd_en   = head_node;
          mem_req.rd_addr = head[IDX_W-1:0];
        end
      end
      S_PUSH_HEAD: begin
        mem_req.wr_data_en = 1'b1;
        mem_req.wr_link_en = 1'b1;
        mem_req.wr_addr    = free_slot[IDX_W-1:0];
        mem_req.wr_data    = item;
        mem_req.wr_link    = head;
      end
      S_POP_TAIL: begin
        if (head_node) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = head[IDX_W-1:0];
        end else begin
          mem_req.wr_data_en = 1'b1;
          mem_req.wr_link_en = 1'b1;
          mem_req.wr_addr    = free_slot[IDX_W-1:0];
          mem_req.wr_data    = item;
          mem_req.wr_link    = NULL_SLOT;
        end
      end
      S_WALK: begin
        if (walk_adv) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mem_rsp.link[IDX_W-1:0];
        end else if (op == CMD_INS_TAIL) begin
          mem_req.wr_link_en = 1'b1;
          mem_req.wr_addr    = cur[IDX_W-1:0];
          mem_req.wr_link    = free_slot;
        end else if (op == CMD_INS_AFTER) begin
          mem_req.rd_en   = hit && free_node;
          mem_req.rd_addr = free_slot[IDX_W-1:0];
        end else if (op == CMD_DEL_TAIL) begin
          mem_req.wr_link_en = prev_node;
          mem_req.wr_addr    = prev[IDX_W-1:0];
          mem_req.wr_link    = NULL_SLOT;
        end else if (op == CMD_DEL_VALUE) begin
          mem_req.wr_link_en = hit && prev_node;
          mem_req.wr_addr    = prev[IDX_W-1:0];
          mem_req.wr_link    = mem_rsp.link;
        end
      end
      S_TAIL_NEW: begin
        mem_req.wr_data_en = 1'b1;
        mem_req.wr_link_en = 1'b1;
        mem_req.wr_addr    = free_slot[IDX_W-1:0];
        mem_req.wr_data    = item;
        mem_req.wr_link    = NULL_SLOT;
      end
      S_INS_A: begin
        mem_req.wr_data_en = 1'b1;
        mem_req.wr_link_en = 1'b1;
        mem_req.wr_addr    = free_slot[IDX_W-1:0];
        mem_req.wr_data    = item;
        mem_req.wr_link    = tnext;
      end
      S_INS_B, S_FREE_T: begin
        mem_req.wr_link_en = 1'b1;
        mem_req.wr_addr    = cur[IDX_W-1:0];
        mem_req.wr_link    = (state == S_INS_B) ? free_slot : free_slot;
      end
      S_DEL_HEAD: begin
        mem_req.wr_link_en = 1'b1;
        mem_req.wr_addr    = head[IDX_W-1:0];
        mem_req.wr_link    = free_slot;
      end
      default: begin
      end
    endcase
  end

  // Command sequencer with list pointers, count and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NULL_SLOT;
      free_slot <= '0;
      count     <= '0;
      done      <= 1'b0;
      status_q  <= ST_OK;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op    <= command.cmd;
            item  <= command.item_value;
            match <= command.match_value;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (op)
            CMD_INS_HEAD, CMD_INS_TAIL: begin
              if (!free_node) begin
                status_q <= ST_FULL;
                done     <= 1'b1;
                state    <= S_IDLE;
              end else begin
                state <= (op == CMD_INS_HEAD) ? S_PUSH_HEAD : S_POP_TAIL;
              end
            end
            CMD_INS_AFTER, CMD_DEL_VALUE, CMD_DEL_TAIL: begin
              if (!head_node) begin
                status_q <= ST_EMPTY;
                done     <= 1'b1;
                state    <= S_IDLE;
              end else begin
                cur   <= head;
                prev  <= NULL_SLOT;
                steps <= (op == CMD_DEL_TAIL) ? SLOT_W'(1) : '0;
                state <= S_WALK;
              end
            end
            CMD_DEL_HEAD: begin
              if (!head_node) begin
                status_q <= ST_EMPTY;
                done     <= 1'b1;
                state    <= S_IDLE;
              end else begin
                state <= S_DEL_HEAD;
              end
            end
            default: begin
              status_q <= ST_OK;
              done     <= 1'b1;
              state    <= S_IDLE;
            end
          endcase
        end
        S_PUSH_HEAD: begin
          head      <= free_slot;
          free_slot <= mem_rsp.link;
          count     <= count + SLOT_W'(1);
          status_q  <= ST_OK;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_POP_TAIL: begin
          nfree <= mem_rsp.link;
          if (head_node) begin
            cur   <= head;
            prev  <= NULL_SLOT;
            steps <= SLOT_W'(1);
            state <= S_WALK;
          end else begin
            head      <= free_slot;
            free_slot <= mem_rsp.link;
            count     <= count + SLOT_W'(1);
            status_q  <= ST_OK;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_WALK: begin
          if (walk_adv) begin
            prev  <= cur;
            cur   <= mem_rsp.link;
            steps <= steps + SLOT_W'(1);
          end else begin
            priority if (op == CMD_INS_TAIL) begin
              state <= S_TAIL_NEW;
            end else if (op == CMD_DEL_TAIL) begin
              if (!prev_node) begin
                head <= NULL_SLOT;
              end
              state <= S_FREE_T;
            end else if (!hit) begin
              status_q <= ST_NOTFOUND;
              done     <= 1'b1;
              state    <= S_IDLE;
            end else if (op == CMD_DEL_VALUE) begin
              if (!prev_node) begin
                head <= mem_rsp.link;
              end
              state <= S_FREE_T;
            end else if (!free_node) begin
              status_q <= ST_FULL;
              done     <= 1'b1;
              state    <= S_IDLE;
            end else begin
              tnext <= mem_rsp.link;
              state <= S_INS_A;
            end
          end
        end
        S_TAIL_NEW: begin
          free_slot <= nfree;
          count     <= count + SLOT_W'(1);
          status_q  <= ST_OK;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_INS_A: begin
          nfree <= mem_rsp.link;
          state <= S_INS_B;
        end
        S_INS_B: begin
          free_slot <= nfree;
          count     <= count + SLOT_W'(1);
          status_q  <= ST_OK;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_DEL_HEAD: begin
          free_slot <= head;
          head      <= mem_rsp.link;
          count     <= count - SLOT_W'(count != '0);
          status_q  <= ST_OK;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_FREE_T: begin
          free_slot <= cur;
          count     <= count - SLOT_W'(count != '0);
          status_q  <= ST_OK;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy               = state != S_IDLE;
  assign result.status      = status_q;
  assign result.entry_total = count;

  // The result strobe comes only as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while a command is still in work");

  // Reset leaves no command in work and no pending result.
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("command or result survived reset");

  // The node count never passes the pool size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= NULL_SLOT)
    else $error("node count beyond pool size");

  // An empty head pointer and a zero count go together between commands.
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ((head == NULL_SLOT) == (count == '0)))
    else $error("head pointer and node count disagree");

  // Pool full is reported only for inserts.
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_FULL)) |->
      ((op == CMD_INS_HEAD) || (op == CMD_INS_TAIL) || (op == CMD_INS_AFTER)))
    else $error("pool full reported for a non-insert command");

endmodule
